FILE: rtl/ragr_pkg.sv
// Package for the rational arithmetic block with gcd reduction.
// Holds widths, action codes and the sequencer state type. No dependencies.
package ragr_pkg;
    localparam int OperandWidth = 16;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int SumWidth     = ProdWidth + 1;
    localparam int NumWidth     = 33;
    localparam int DenWidth     = 31;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_CMP = 3'd4
    } t_action;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_LT = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_OUT
    } t_state;
endpackage

FILE: rtl/ragr_divider.sv
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on ragr_pkg.
module ragr_divider
    import ragr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SumWidth-1:0]  i_dividend,
    input  logic [SumWidth-1:0]  i_divisor,
    output logic                 o_done,
    output logic [SumWidth-1:0]  o_quotient,
    output logic [SumWidth-1:0]  o_remainder
);
    localparam int CntWidth = $clog2(SumWidth + 1);

    logic [SumWidth-1:0] r_q, r_d;
    logic [SumWidth-1:0] r_rem;
    logic [CntWidth-1:0] r_cnt;
    logic                r_busy, r_done;
    logic [SumWidth:0]   w_shift, w_diff;

    assign w_shift = {r_rem, r_q[SumWidth-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntWidth'(SumWidth);
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_diff[SumWidth]) begin
                    r_rem <= w_diff[SumWidth-1:0];
                    r_q   <= {r_q[SumWidth-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[SumWidth-1:0];
                    r_q   <= {r_q[SumWidth-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CntWidth'(1);
                if (r_cnt == CntWidth'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
endmodule

FILE: rtl/rational_arith_gcd_reduce.sv
// Top level: rational add/sub/mul/div/compare with gcd reduction.
// Depends on ragr_pkg and ragr_divider.
//
// channel  direction  signals
// input    in         i_valid, o_stall, i_action, i_a_*, i_b_*
// output   out        o_valid, i_stall, o_result_*, o_order, o_zero_denominator
//
// One transaction at a time. Four products go through one 16x16 multiplier,
// then Euclid's loop runs modulo steps on the shared divider, and two more
// divisions on the same divider reduce the result. Compare and unused actions
// skip the gcd loop and the divisions and go straight to o_valid.
// Synchronous active-low reset; o_stall is high while busy or holding a result.
module rational_arith_gcd_reduce
    import ragr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [2:0]                  i_action,
    input  logic signed [OperandWidth-1:0] i_a_numerator,
    input  logic signed [OperandWidth-1:0] i_a_denominator,
    input  logic signed [OperandWidth-1:0] i_b_numerator,
    input  logic signed [OperandWidth-1:0] i_b_denominator,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [NumWidth-1:0]  o_result_numerator,
    output logic [DenWidth-1:0]         o_result_denominator,
    output logic [1:0]                  o_order,
    output logic                        o_zero_denominator
);
    t_state r_state, n_state;
    logic [2:0]  r_act;
    logic signed [OperandWidth-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [ProdWidth-1:0] r_p0, r_p1, r_p2;
    logic [1:0]  r_mcnt;
    logic signed [SumWidth-1:0] r_num, r_den;
    logic [SumWidth-1:0] r_x, r_y, r_nmag, r_dmag;
    logic        r_neg, r_flag, r_dstart, r_wait;
    logic signed [NumWidth-1:0] r_on;
    logic [DenWidth-1:0] r_od;
    logic [1:0]  r_ord;

    logic signed [OperandWidth-1:0] w_ma, w_mb;
    logic signed [ProdWidth-1:0]    w_prod;
    logic [SumWidth-1:0] w_dvd, w_dvs, w_quo, w_rem;
    logic        w_done, w_arith;
    logic signed [SumWidth-1:0] w_pa, w_pb, w_pc;

    ragr_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_dividend(w_dvd), .i_divisor(w_dvs),
        .o_done(w_done), .o_quotient(w_quo), .o_remainder(w_rem)
    );

    assign w_arith = (r_act == ACT_ADD) || (r_act == ACT_SUB) ||
                     (r_act == ACT_MUL) || (r_act == ACT_DIV);

    // multiplier operand select per step
    always_comb begin
        w_ma = r_an;
        w_mb = r_bd;
        case (r_mcnt)
            2'd0: begin w_ma = r_an; w_mb = r_bd; end
            2'd1: begin w_ma = r_ad; w_mb = r_bn; end
            2'd2: begin w_ma = r_ad; w_mb = r_bd; end
            2'd3: begin w_ma = r_an; w_mb = r_bn; end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_pa = SumWidth'(r_p0);
    assign w_pb = SumWidth'(r_p1);
    assign w_pc = SumWidth'(r_p2);

    always_comb begin
        w_dvd = r_x;
        w_dvs = r_y;
        if (r_state == ST_DIVN) begin
            w_dvd = r_nmag; w_dvs = r_x;
        end else if (r_state == ST_DIVD) begin
            w_dvd = r_dmag; w_dvs = r_x;
        end else if (r_x <= r_y) begin
            w_dvd = r_y; w_dvs = r_x;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL:  if (r_mcnt == 2'd3) n_state = ST_SUM;
            ST_SUM:  n_state = w_arith ? ST_GCD : ST_OUT;
            ST_GCD:  if (!r_wait && (r_x == '0 || r_y == '0)) n_state = ST_DIVN;
            ST_DIVN: if (w_done) n_state = ST_DIVD;
            ST_DIVD: if (w_done) n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_dstart <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_act  <= i_action;
                        r_an   <= i_a_numerator;
                        r_bn   <= i_b_numerator;
                        r_ad   <= (i_a_denominator == '0) ? OperandWidth'(1) : i_a_denominator;
                        r_bd   <= (i_b_denominator == '0) ? OperandWidth'(1) : i_b_denominator;
                        r_flag <= (i_a_denominator == '0) || (i_b_denominator == '0);
                        r_mcnt <= 2'd0;
                        r_ord  <= ORD_EQ;
                    end
                end
                ST_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    case (r_mcnt)
                        2'd0: r_p0 <= w_prod;
                        2'd1: r_p1 <= w_prod;
                        2'd2: r_p2 <= w_prod;
                        default: ;
                    endcase
                    if (r_mcnt == 2'd3) begin
                        case (r_act)
                            ACT_ADD: begin r_num <= w_pa + w_pb; r_den <= w_pc; end
                            ACT_SUB: begin r_num <= w_pa - w_pb; r_den <= w_pc; end
                            ACT_MUL: begin r_num <= SumWidth'(w_prod); r_den <= w_pc; end
                            ACT_DIV: begin r_num <= w_pa; r_den <= w_pb; end
                            default: begin r_num <= '0; r_den <= SumWidth'(1); end
                        endcase
                    end
                end
                ST_SUM: begin
                    if (r_act == ACT_CMP) begin
                        // a/b order: an*bd vs bn*ad, sign of ad*bd fixes direction
                        if (w_pa == w_pb) r_ord <= ORD_EQ;
                        else if ((w_pa < w_pb) != w_pc[SumWidth-1]) r_ord <= ORD_LT;
                        else r_ord <= ORD_GT;
                    end
                    if (r_den == '0) r_flag <= r_flag | w_arith;
                    r_neg  <= (r_num != '0) && (r_num[SumWidth-1] != r_den[SumWidth-1]);
                    r_nmag <= r_num[SumWidth-1] ? -r_num : r_num;
                    r_x    <= r_num[SumWidth-1] ? -r_num : r_num;
                    if (r_den == '0) begin
                        r_dmag <= SumWidth'(1); r_y <= SumWidth'(1);
                    end else begin
                        r_dmag <= r_den[SumWidth-1] ? -r_den : r_den;
                        r_y    <= r_den[SumWidth-1] ? -r_den : r_den;
                    end
                    r_on <= '0;
                    r_od <= DenWidth'(1);
                end
                ST_GCD: begin
                    if (r_wait) begin
                        if (w_done) begin
                            r_wait <= 1'b0;
                            if (r_x > r_y) r_x <= w_rem;
                            else r_y <= w_rem;
                        end
                    end else if (r_x == '0 || r_y == '0) begin
                        r_x      <= r_x | r_y;
                        r_dstart <= 1'b1;
                    end else begin
                        r_dstart <= 1'b1;
                        r_wait   <= 1'b1;
                    end
                end
                ST_DIVN: begin
                    if (w_done) begin
                        r_on     <= r_neg ? NumWidth'(-w_quo) : NumWidth'(w_quo);
                        r_dstart <= 1'b1;
                    end
                end
                ST_DIVD: if (w_done) r_od <= DenWidth'(w_quo);
                default: ;
            endcase
        end
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = (r_state == ST_OUT);
    assign o_result_numerator   = r_on;
    assign o_result_denominator = r_od;
    assign o_order              = r_ord;
    assign o_zero_denominator   = r_flag;
endmodule
